### rtl/tcpst_pkg.sv
// Package for the TCP connection state tracker.
// Holds command, phase and flag codes, item and result types, shared sizes.
// No dependencies.
package tcpst_pkg;

  localparam int RING_ADDR_BITS = 16;
  localparam logic [16:0] RING_LIM = 17'((64'd1 << RING_ADDR_BITS) - 64'd1);
  localparam logic [15:0] WINDOW_RESET = 16'hFFFF;
  localparam logic [15:0] LINGER_RESET = 16'd300;
  localparam int OQ_DEPTH = 4;
  localparam int IQ_DEPTH = 2;

  localparam logic [7:0] F_FIN = 8'h01;
  localparam logic [7:0] F_SYN = 8'h02;
  localparam logic [7:0] F_RST = 8'h04;
  localparam logic [7:0] F_ACK = 8'h10;

  localparam logic [1:0] REG_WINDOW = 2'd0;
  localparam logic [1:0] REG_TWAIT  = 2'd1;

  localparam logic KIND_SEG  = 1'b0;
  localparam logic KIND_READ = 1'b1;

  typedef enum logic [2:0] {
    CMD_SEG     = 3'd0,
    CMD_CONNECT = 3'd1,
    CMD_LISTEN  = 3'd2,
    CMD_CLOSE   = 3'd3,
    CMD_WRITE   = 3'd4,
    CMD_READ    = 3'd5,
    CMD_TICK    = 3'd6,
    CMD_UNUSED  = 3'd7
  } cmd_t;

  typedef enum logic [3:0] {
    P_CLOSED      = 4'd0,
    P_SYN_SENT    = 4'd1,
    P_ESTABLISHED = 4'd2,
    P_LISTEN      = 4'd3,
    P_SYN_RCVD    = 4'd4,
    P_FIN_WAIT1   = 4'd5,
    P_FIN_WAIT2   = 4'd6,
    P_TIME_WAIT   = 4'd7,
    P_CLOSING     = 4'd8,
    P_CLOSE_WAIT  = 4'd9,
    P_LAST_ACK    = 4'd10
  } phase_t;

  typedef enum logic {
    EX_RUN = 1'b0,
    EX_MOD = 1'b1
  } exec_state_t;

  typedef struct packed {
    logic        known;
    cmd_t        cmd;
    logic [7:0]  flags;
    logic [31:0] seq;
    logic [15:0] len;
  } item_t;

  typedef struct packed {
    logic        kind;
    logic        last;
    logic [7:0]  flags;
    logic [31:0] seq;
    logic [31:0] ack;
    logic [15:0] win;
    logic [15:0] off;
    logic [15:0] cnt;
    logic [3:0]  state;
  } res_t;

  typedef struct packed {
    logic       mod_busy;
    logic       pop;
    logic [2:0] qcnt;
  } exec_status_t;

  function automatic logic [15:0] free_space(input logic [15:0] cap, input logic [16:0] fill);
    logic [16:0] d;
    d = {1'b0, cap} - fill;
    return (fill >= {1'b0, cap}) ? 16'd0 : d[15:0];
  endfunction

endpackage

### rtl/tcpst_if.sv
// Channel interfaces for the TCP connection state tracker.
// No dependencies.
interface tcpst_in_if;
  logic        valid;
  logic        ready;
  logic [2:0]  cmd;
  logic [7:0]  seg_flags;
  logic [31:0] seg_seq;
  logic [15:0] length;
  modport source(output valid, cmd, seg_flags, seg_seq, length, input ready);
  modport sink(input valid, cmd, seg_flags, seg_seq, length, output ready);
endinterface

interface tcpst_out_if;
  logic        valid;
  logic        ready;
  logic        kind;
  logic        last;
  logic [7:0]  tx_flags;
  logic [31:0] tx_seq;
  logic [31:0] tx_ack;
  logic [15:0] tx_window;
  logic [15:0] ring_offset;
  logic [15:0] byte_count;
  logic [3:0]  conn_state;
  modport source(output valid, kind, last, tx_flags, tx_seq, tx_ack, tx_window, ring_offset,
                 byte_count, conn_state, input ready);
  modport sink(input valid, kind, last, tx_flags, tx_seq, tx_ack, tx_window, ring_offset,
               byte_count, conn_state, output ready);
endinterface

interface tcpst_cfg_if;
  logic        valid;
  logic        ready;
  logic [1:0]  index;
  logic [15:0] data;
  modport source(output valid, index, data, input ready);
  modport sink(input valid, index, data, output ready);
endinterface

### rtl/tcpst_front.sv
// Front end: accepts commands, decodes them and queues them for execution.
// Depends on tcpst_pkg and tcpst_if.
module tcpst_front (
  input  logic            clk,
  input  logic            rst_n,
  tcpst_in_if.sink        in_ch,
  output tcpst_pkg::item_t item,
  output logic            item_valid,
  input  logic            item_pop
);
  import tcpst_pkg::*;

  item_t       q_r [IQ_DEPTH];
  logic        wp_r, wp_nxt, rp_r, rp_nxt;
  logic [1:0]  cnt_r, cnt_nxt;
  logic        push;
  item_t       dec;

  always_comb begin
    dec.known = (in_ch.cmd != CMD_UNUSED);
    dec.cmd   = cmd_t'(in_ch.cmd);
    dec.flags = in_ch.seg_flags;
    dec.seq   = in_ch.seg_seq;
    dec.len   = in_ch.length;
  end

  assign in_ch.ready = (cnt_r != 2'd2);
  assign push        = in_ch.valid && in_ch.ready;
  assign item_valid  = (cnt_r != 2'd0);
  assign item        = q_r[rp_r];

  always_comb begin
    wp_nxt  = push ? ~wp_r : wp_r;
    rp_nxt  = item_pop ? ~rp_r : rp_r;
    cnt_nxt = cnt_r + {1'b0, push} - {1'b0, item_pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q_r[wp_r] <= dec;
    end
  end

endmodule

### rtl/tcpst_exec.sv
// Back end: connection state, sequence numbers, ring bookkeeping and result queue.
// Wraps ring positions with a serial remainder unit when one subtract is not enough.
// Depends on tcpst_pkg and tcpst_if.
module tcpst_exec (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic [15:0]              wnd_cfg,
  input  logic [15:0]              time_wait_ticks,
  input  tcpst_pkg::item_t         item,
  input  logic                     item_valid,
  output logic                     item_pop,
  tcpst_out_if.source              out_ch,
  output tcpst_pkg::exec_status_t  status
);
  import tcpst_pkg::*;

  exec_state_t st_r, st_nxt;
  phase_t      phase_r;
  logic [31:0] sseq_r, rack_r;
  logic [15:0] head_r, tail_r;
  logic [16:0] fill_r;
  logic [15:0] lcount_r;
  logic        lact_r;

  logic [16:0] mnum_r, mrem_r, mrem_nxt, msh;
  logic [4:0]  mcnt_r;
  logic        mhead_r;

  res_t        q_r [OQ_DEPTH];
  logic [1:0]  qwp_r, qrp_r;
  logic [2:0]  qcnt_r, qcnt_nxt;

  logic [15:0] cap;
  phase_t      ph;
  logic [31:0] ss, ra;
  logic [15:0] hd, tl, lc, at, rcnt;
  logic [16:0] fl, sum;
  logic        la, clr;
  logic [1:0]  n;
  res_t        r0, r1, rs;
  logic        mod_req, mod_head;
  logic [16:0] mod_sum;
  logic        dp, fire, mod_done, pop_out;

  always_comb begin
    cap = (wnd_cfg == 16'd0) ? 16'd1 : wnd_cfg;
    if ({1'b0, cap} > RING_LIM) begin
      cap = RING_LIM[15:0];
    end
  end

  assign fire     = (st_r == EX_RUN) && item_valid && (qcnt_r <= 3'd2);
  assign mod_done = (st_r == EX_MOD) && (mcnt_r == 5'd0);
  assign pop_out  = out_ch.valid && out_ch.ready;

  always_comb begin
    st_nxt = st_r;
    case (st_r)
      EX_RUN: begin
        if (fire && mod_req) st_nxt = EX_MOD;
      end
      EX_MOD: begin
        if (mcnt_r == 5'd0) st_nxt = EX_RUN;
      end
      default: st_nxt = EX_RUN;
    endcase
  end

  always_comb begin
    item_pop        = fire;
    status.mod_busy = (st_r == EX_MOD);
    status.pop      = fire;
    status.qcnt     = qcnt_r;
  end

  always_comb begin
    msh = {mrem_r[15:0], mnum_r[mcnt_r]};
    mrem_nxt = (msh >= {1'b0, cap}) ? msh - {1'b0, cap} : msh;
  end

  function automatic res_t mk_seg(input logic [7:0] f, input logic [31:0] s,
                                  input logic [31:0] a, input logic [15:0] w,
                                  input logic [15:0] o, input logic [15:0] c);
    res_t r;
    r.kind = KIND_SEG; r.last = 1'b0; r.flags = f; r.seq = s; r.ack = a;
    r.win = w; r.off = o; r.cnt = c; r.state = 4'd0;
    return r;
  endfunction

  always_comb begin
    ph = phase_r; ss = sseq_r; ra = rack_r; hd = head_r; tl = tail_r; fl = fill_r;
    lc = lcount_r; la = lact_r; clr = 1'b0;
    n = 2'd0; r0 = '0; r1 = '0; rs = '0;
    mod_req = 1'b0; mod_head = 1'b0; mod_sum = '0; dp = 1'b0;
    at = 16'd0; sum = '0; rcnt = 16'd0;
    if (item.known) begin
      case (item.cmd)
        CMD_SEG: begin
          case (ph)
            P_LISTEN: begin
              if (item.flags == F_SYN) begin
                ph = P_SYN_RCVD; ss = 32'd0; ra = item.seq + 32'd1;
                hd = 16'd0; tl = 16'd0; fl = 17'd0;
                r0 = mk_seg(F_SYN | F_ACK, ss, ra, free_space(cap, fl), 16'd0, 16'd0);
                n = 2'd1; ss = ss + 32'd1;
              end
            end
            P_SYN_RCVD: begin
              if (item.flags == F_ACK) ph = P_ESTABLISHED;
            end
            P_SYN_SENT: begin
              if ((item.flags & (F_SYN | F_ACK)) == (F_SYN | F_ACK)) begin
                ra = item.seq + 32'd1;
                r0 = mk_seg(F_ACK, ss, ra, free_space(cap, fl), 16'd0, 16'd0);
                n = 2'd1; ph = P_ESTABLISHED;
              end
            end
            P_TIME_WAIT: begin
              if ((item.flags & F_FIN) != 8'd0) begin
                r0 = mk_seg(F_ACK, ss, ra, free_space(cap, fl), 16'd0, 16'd0);
                n = 2'd1;
              end
            end
            P_LAST_ACK: begin
              if ((item.flags & F_ACK) != 8'd0 && !la) begin
                la = 1'b1; lc = time_wait_ticks;
              end
            end
            P_CLOSING: begin
              if ((item.flags & F_ACK) != 8'd0) begin
                ph = P_TIME_WAIT;
                if (!la) begin
                  la = 1'b1; lc = time_wait_ticks;
                end
              end
            end
            P_FIN_WAIT1: begin
              dp = 1'b1;
              if ((item.flags & F_ACK) != 8'd0) begin
                ph = P_FIN_WAIT2;
              end else if ((item.flags & F_FIN) != 8'd0) begin
                ph = P_CLOSING; ra = item.seq + 32'd1;
                r0 = mk_seg(F_ACK, ss, ra, free_space(cap, fl), 16'd0, 16'd0);
                n = 2'd1;
              end
            end
            P_FIN_WAIT2, P_ESTABLISHED: dp = 1'b1;
            default: dp = 1'b0;
          endcase
          if (dp && item.seq == ra && (item.flags & F_RST) == 8'd0 &&
              (item.flags & F_ACK) != 8'd0 && free_space(cap, fl) >= item.len) begin
            at = tl;
            fl = fl + {1'b0, item.len};
            sum = {1'b0, tl} + {1'b0, item.len};
            if (sum < {1'b0, cap}) begin
              tl = sum[15:0];
            end else if (sum - {1'b0, cap} < {1'b0, cap}) begin
              tl = 16'(sum - {1'b0, cap});
            end else begin
              mod_req = 1'b1; mod_sum = sum;
            end
            ra = ra + {16'd0, item.len};
            r0 = mk_seg(F_ACK, ss, ra, free_space(cap, fl), at, item.len);
            n = 2'd1;
            if ((item.flags & F_FIN) != 8'd0) begin
              ra = ra + 32'd1;
              r1 = mk_seg(F_ACK, ss, ra, free_space(cap, fl), 16'd0, 16'd0);
              n = 2'd2;
              if (ph == P_FIN_WAIT2) begin
                ph = P_TIME_WAIT;
                if (!la) begin
                  la = 1'b1; lc = time_wait_ticks;
                end
              end else begin
                ph = P_CLOSE_WAIT;
              end
            end
          end
        end
        CMD_CONNECT: begin
          if (ph == P_CLOSED) begin
            r0 = mk_seg(F_SYN, ss, ra, free_space(cap, fl), 16'd0, 16'd0);
            n = 2'd1; ss = ss + 32'd1; ph = P_SYN_SENT;
          end
        end
        CMD_LISTEN: begin
          if (ph == P_CLOSED) ph = P_LISTEN;
        end
        CMD_CLOSE: begin
          if (ph == P_ESTABLISHED || ph == P_CLOSE_WAIT) begin
            r0 = mk_seg(F_FIN | F_ACK, ss, ra, free_space(cap, fl), 16'd0, 16'd0);
            n = 2'd1; ss = ss + 32'd1;
            ph = (ph == P_ESTABLISHED) ? P_FIN_WAIT1 : P_LAST_ACK;
          end else if (ph == P_LISTEN) begin
            ph = P_CLOSED;
          end else if (ph != P_CLOSED && !la) begin
            la = 1'b1; lc = time_wait_ticks;
          end
        end
        CMD_WRITE: begin
          r0 = mk_seg(F_ACK, ss, ra, free_space(cap, fl), 16'd0, item.len);
          n = 2'd1; ss = ss + {16'd0, item.len};
        end
        CMD_READ: begin
          rcnt = ({1'b0, item.len} < fl) ? item.len : fl[15:0];
          at = hd;
          sum = {1'b0, hd} + {1'b0, rcnt};
          if (sum < {1'b0, cap}) begin
            hd = sum[15:0];
          end else if (sum - {1'b0, cap} < {1'b0, cap}) begin
            hd = 16'(sum - {1'b0, cap});
          end else begin
            mod_req = 1'b1; mod_head = 1'b1; mod_sum = sum;
          end
          fl = fl - {1'b0, rcnt};
          rs.kind = KIND_READ; rs.off = at; rs.cnt = rcnt;
          r0 = rs; n = 2'd1;
        end
        CMD_TICK: begin
          if (la) begin
            if (lc <= 16'd1) clr = 1'b1;
            else lc = lc - 16'd1;
          end
        end
        default: n = 2'd0;
      endcase
    end
    if (clr) begin
      ph = P_CLOSED; ss = '0; ra = '0; hd = '0; tl = '0; fl = '0; lc = '0; la = 1'b0;
    end
    r0.state = ph;
    r1.state = ph;
    r0.last  = (n == 2'd1);
    r1.last  = 1'b1;
  end

  always_comb begin
    qcnt_nxt = qcnt_r + (fire ? {1'b0, n} : 3'd0) - {2'd0, pop_out};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r     <= EX_RUN;
      phase_r  <= P_CLOSED;
      sseq_r   <= '0;
      rack_r   <= '0;
      head_r   <= '0;
      tail_r   <= '0;
      fill_r   <= '0;
      lcount_r <= '0;
      lact_r   <= 1'b0;
      qwp_r    <= '0;
      qrp_r    <= '0;
      qcnt_r   <= '0;
      mcnt_r   <= '0;
    end else begin
      st_r   <= st_nxt;
      qcnt_r <= qcnt_nxt;
      if (pop_out) qrp_r <= qrp_r + 2'd1;
      if (fire) begin
        phase_r  <= ph;
        sseq_r   <= ss;
        rack_r   <= ra;
        head_r   <= hd;
        tail_r   <= tl;
        fill_r   <= fl;
        lcount_r <= lc;
        lact_r   <= la;
        qwp_r    <= qwp_r + n;
        mcnt_r   <= 5'd16;
      end else if (st_r == EX_MOD) begin
        if (mod_done) begin
          if (mhead_r) head_r <= mrem_nxt[15:0];
          else tail_r <= mrem_nxt[15:0];
        end else begin
          mcnt_r <= mcnt_r - 5'd1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      mnum_r  <= mod_sum;
      mrem_r  <= '0;
      mhead_r <= mod_head;
      if (n != 2'd0) q_r[qwp_r] <= r0;
      if (n == 2'd2) q_r[qwp_r + 2'd1] <= r1;
    end else if (st_r == EX_MOD) begin
      mrem_r <= mrem_nxt;
    end
  end

  always_comb begin
    out_ch.valid       = (qcnt_r != 3'd0);
    out_ch.kind        = q_r[qrp_r].kind;
    out_ch.last        = q_r[qrp_r].last;
    out_ch.tx_flags    = q_r[qrp_r].flags;
    out_ch.tx_seq      = q_r[qrp_r].seq;
    out_ch.tx_ack      = q_r[qrp_r].ack;
    out_ch.tx_window   = q_r[qrp_r].win;
    out_ch.ring_offset = q_r[qrp_r].off;
    out_ch.byte_count  = q_r[qrp_r].cnt;
    out_ch.conn_state  = q_r[qrp_r].state;
  end

endmodule

### rtl/tcp_connection_state_tracker.sv
// TCP connection state tracker, one connection slot.
// Commands and segment headers come in on in_ch, transmit segments and read
// completions leave on out_ch, and cfg_ch sets window size and linger ticks.
// Each result leaves as one output transfer, and the execution stage takes an
// item only while the result queue has room for two results and no remainder
// is in progress. When a ring position wraps past the capacity by more than one
// lap, a serial remainder unit finishes before the next item starts. Depends on
// tcpst_pkg, tcpst_if, tcpst_front and tcpst_exec.
module tcp_connection_state_tracker (
  input  logic        clk,
  input  logic        rst_n,
  tcpst_in_if.sink    in_ch,
  tcpst_out_if.source out_ch,
  tcpst_cfg_if.sink   cfg_ch
);
  import tcpst_pkg::*;

  logic [15:0]  window_r, twait_r;
  item_t        item;
  logic         item_valid, item_pop;
  exec_status_t status;

  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      window_r <= WINDOW_RESET;
      twait_r  <= LINGER_RESET;
    end else if (cfg_ch.valid) begin
      if (cfg_ch.index == REG_WINDOW) window_r <= cfg_ch.data;
      if (cfg_ch.index == REG_TWAIT) twait_r <= cfg_ch.data;
    end
  end

  tcpst_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_ch      (in_ch),
    .item       (item),
    .item_valid (item_valid),
    .item_pop   (item_pop)
  );

  tcpst_exec u_exec (
    .clk             (clk),
    .rst_n           (rst_n),
    .wnd_cfg         (window_r),
    .time_wait_ticks (twait_r),
    .item            (item),
    .item_valid      (item_valid),
    .item_pop        (item_pop),
    .out_ch          (out_ch),
    .status          (status)
  );

  a_no_pop_in_mod: assert property (@(posedge clk) disable iff (!rst_n)
    status.mod_busy |-> !status.pop) else $error("item taken during remainder");
  a_qcnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    status.qcnt <= 3'(OQ_DEPTH)) else $error("result queue overflow");
  a_pop_valid: assert property (@(posedge clk) disable iff (!rst_n)
    item_pop |-> item_valid) else $error("pop from empty input queue");
  a_state_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid |-> out_ch.conn_state <= P_LAST_ACK) else $error("bad phase code");

endmodule

### verif/tcp_connection_state_tracker_test.sv
// Self-checking test of the TCP connection state tracker.
// A scoreboard class predicts every transmit segment and read completion and
// checks the outputs in order. Depends on tcpst_pkg, tcpst_if and the block.
`timescale 1ns / 100ps

module tcp_connection_state_tracker_test;
  import tcpst_pkg::*;

  class conn_scoreboard;
    logic [15:0] window;
    logic [15:0] twait;
    phase_t      phase;
    logic [31:0] snd_nxt;
    logic [31:0] rcv_ack;
    int unsigned head, tail, fill, lcount;
    bit          lactive;
    res_t        expq[$];
    res_t        step_q[$];
    int          errors;

    function new();
      window = WINDOW_RESET;
      twait = LINGER_RESET;
      errors = 0;
      clear_conn();
    endfunction

    function void clear_conn();
      phase = P_CLOSED;
      snd_nxt = 0;
      rcv_ack = 0;
      head = 0;
      tail = 0;
      fill = 0;
      lcount = 0;
      lactive = 0;
    endfunction

    function void write_reg(logic [1:0] idx, logic [15:0] val);
      if (idx == REG_WINDOW) window = val;
      else if (idx == REG_TWAIT) twait = val;
    endfunction

    function int unsigned cap();
      return (window == 0) ? 1 : window;
    endfunction

    function int unsigned room();
      return (fill >= cap()) ? 0 : cap() - fill;
    endfunction

    function void emit_seg(logic [7:0] flags, logic [15:0] len);
      res_t r;
      r = '0;
      r.kind = KIND_SEG;
      r.flags = flags;
      r.seq = snd_nxt;
      r.ack = rcv_ack;
      r.win = 16'(room());
      r.cnt = len;
      step_q.push_back(r);
      snd_nxt += len;
      if ((flags & (F_SYN | F_FIN)) != 0) snd_nxt += 1;
    endfunction

    function void start_linger();
      if (!lactive) begin
        lactive = 1;
        lcount = twait;
      end
    endfunction

    function void take_segment(logic [7:0] flags, logic [31:0] seq, logic [15:0] len);
      int unsigned at;
      res_t r;
      case (phase)
        P_LISTEN: begin
          if (flags == F_SYN) begin
            phase = P_SYN_RCVD;
            snd_nxt = 0;
            rcv_ack = seq + 1;
            head = 0;
            tail = 0;
            fill = 0;
            emit_seg(F_SYN | F_ACK, 0);
          end
          return;
        end
        P_SYN_RCVD: begin
          if (flags == F_ACK) phase = P_ESTABLISHED;
          return;
        end
        P_SYN_SENT: begin
          if ((flags & (F_SYN | F_ACK)) == (F_SYN | F_ACK)) begin
            rcv_ack = seq + 1;
            emit_seg(F_ACK, 0);
            phase = P_ESTABLISHED;
          end
          return;
        end
        P_TIME_WAIT: begin
          if ((flags & F_FIN) != 0) emit_seg(F_ACK, 0);
          return;
        end
        P_LAST_ACK: begin
          if ((flags & F_ACK) != 0) start_linger();
          return;
        end
        P_CLOSING: begin
          if ((flags & F_ACK) != 0) begin
            phase = P_TIME_WAIT;
            start_linger();
          end
          return;
        end
        P_FIN_WAIT1: begin
          if ((flags & F_ACK) != 0) begin
            phase = P_FIN_WAIT2;
          end else if ((flags & F_FIN) != 0) begin
            phase = P_CLOSING;
            rcv_ack = seq + 1;
            emit_seg(F_ACK, 0);
          end
        end
        P_FIN_WAIT2, P_ESTABLISHED: ;
        default: return;
      endcase
      if (seq != rcv_ack || (flags & F_RST) != 0 || (flags & F_ACK) == 0) return;
      if (room() < len) return;
      at = tail;
      fill += len;
      tail = (tail + len) % cap();
      rcv_ack += len;
      emit_seg(F_ACK, 0);
      r = step_q.pop_back();
      r.off = 16'(at);
      r.cnt = len;
      step_q.push_back(r);
      if ((flags & F_FIN) != 0) begin
        rcv_ack += 1;
        emit_seg(F_ACK, 0);
        if (phase == P_FIN_WAIT2) begin
          phase = P_TIME_WAIT;
          start_linger();
        end else begin
          phase = P_CLOSE_WAIT;
        end
      end
    endfunction

    function void note_item(logic [2:0] cmd, logic [7:0] flags, logic [31:0] seq,
                            logic [15:0] len);
      int unsigned cnt;
      res_t r;
      step_q.delete();
      case (cmd)
        CMD_SEG: take_segment(flags, seq, len);
        CMD_CONNECT: begin
          if (phase == P_CLOSED) begin
            emit_seg(F_SYN, 0);
            phase = P_SYN_SENT;
          end
        end
        CMD_LISTEN: if (phase == P_CLOSED) phase = P_LISTEN;
        CMD_CLOSE: begin
          if (phase == P_ESTABLISHED) begin
            emit_seg(F_FIN | F_ACK, 0);
            phase = P_FIN_WAIT1;
          end else if (phase == P_CLOSE_WAIT) begin
            emit_seg(F_FIN | F_ACK, 0);
            phase = P_LAST_ACK;
          end else if (phase == P_LISTEN) begin
            phase = P_CLOSED;
          end else if (phase != P_CLOSED) begin
            start_linger();
          end
        end
        CMD_WRITE: emit_seg(F_ACK, len);
        CMD_READ: begin
          cnt = (len < fill) ? len : fill;
          r = '0;
          r.kind = KIND_READ;
          r.off = 16'(head);
          r.cnt = 16'(cnt);
          head = (head + cnt) % cap();
          fill -= cnt;
          step_q.push_back(r);
        end
        CMD_TICK: begin
          if (lactive) begin
            if (lcount <= 1) clear_conn();
            else lcount--;
          end
        end
        default: ;
      endcase
      foreach (step_q[k]) begin
        step_q[k].state = phase;
        step_q[k].last = (k == step_q.size() - 1);
        expq.push_back(step_q[k]);
      end
    endfunction

    function void check_result(res_t got);
      res_t e;
      if (expq.size() == 0) begin
        $display("%0t: unexpected result %h", $time, got);
        errors++;
        return;
      end
      e = expq.pop_front();
      if (got.kind !== e.kind || got.last !== e.last || got.flags !== e.flags ||
          got.seq !== e.seq || got.ack !== e.ack || got.win !== e.win ||
          got.off !== e.off || got.cnt !== e.cnt || got.state !== e.state) begin
        $display({"%0t: mismatch expected kind=%0d last=%0d flags=%h seq=%h ack=%h",
                  " win=%0d off=%0d cnt=%0d st=%0d"},
                 $time, e.kind, e.last, e.flags, e.seq, e.ack, e.win, e.off, e.cnt,
                 e.state);
        $display({"%0t:          actual   kind=%0d last=%0d flags=%h seq=%h ack=%h",
                  " win=%0d off=%0d cnt=%0d st=%0d"},
                 $time, got.kind, got.last, got.flags, got.seq, got.ack, got.win,
                 got.off, got.cnt, got.state);
        errors++;
      end
    endfunction
  endclass

  logic clk;
  logic rst_n;
  int   send_idle_pct;
  int   recv_stall_pct;

  tcpst_in_if  in_ch();
  tcpst_out_if out_ch();
  tcpst_cfg_if cfg_ch();

  conn_scoreboard sb;

  tcp_connection_state_tracker i_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  initial begin
    #10_000_000;
    $display("Test completed with failures");
    $finish;
  end

  always @(negedge clk) begin
    out_ch.ready = ($urandom_range(99) >= recv_stall_pct);
  end

  always @(posedge clk) begin
    res_t got;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      got.kind = out_ch.kind;
      got.last = out_ch.last;
      got.flags = out_ch.tx_flags;
      got.seq = out_ch.tx_seq;
      got.ack = out_ch.tx_ack;
      got.win = out_ch.tx_window;
      got.off = out_ch.ring_offset;
      got.cnt = out_ch.byte_count;
      got.state = out_ch.conn_state;
      sb.check_result(got);
    end
  end

  task automatic write_cfg(logic [1:0] idx, logic [15:0] val);
    @(negedge clk);
    cfg_ch.valid = 1'b1;
    cfg_ch.index = idx;
    cfg_ch.data = val;
    do @(posedge clk); while (!cfg_ch.ready);
    sb.write_reg(idx, val);
    @(negedge clk);
    cfg_ch.valid = 1'b0;
  endtask

  task automatic send_item(logic [2:0] cmd, logic [7:0] flags, logic [31:0] seq,
                           logic [15:0] len);
    while ($urandom_range(99) < send_idle_pct) begin
      in_ch.valid = 1'b0;
      @(negedge clk);
    end
    in_ch.valid = 1'b1;
    in_ch.cmd = cmd;
    in_ch.seg_flags = flags;
    in_ch.seg_seq = seq;
    in_ch.length = len;
    do @(posedge clk); while (!in_ch.ready);
    sb.note_item(cmd, flags, seq, len);
    @(negedge clk);
    in_ch.valid = 1'b0;
  endtask

  task automatic drain();
    while (sb.expq.size() != 0) @(negedge clk);
    repeat (40) @(negedge clk);
  endtask

  function automatic logic [15:0] pick_len();
    int r;
    r = $urandom_range(99);
    if (r < 50) return 16'($urandom_range(64));
    if (r < 80) return 16'($urandom_range(sb.room() > 65535 ? 65535 : sb.room()));
    if (r < 90) return 16'hFFFF;
    return 16'($urandom_range(65535));
  endfunction

  task automatic random_item();
    int r;
    logic [7:0] fl;
    r = $urandom_range(99);
    if (r < 12) begin
      send_item(3'($urandom_range(7)), 8'($urandom), $urandom, 16'($urandom_range(65535)));
      return;
    end
    if (sb.lactive && r < 45) begin
      send_item(CMD_TICK, 0, 0, 0);
      return;
    end
    case (sb.phase)
      P_CLOSED: send_item($urandom_range(1) ? CMD_CONNECT : CMD_LISTEN, 0, 0, 0);
      P_LISTEN: send_item(CMD_SEG, (r < 85) ? F_SYN : 8'($urandom), $urandom, pick_len());
      P_SYN_RCVD: send_item(CMD_SEG, (r < 85) ? F_ACK : 8'($urandom), $urandom, pick_len());
      P_SYN_SENT: send_item(CMD_SEG, F_SYN | F_ACK, $urandom, pick_len());
      default: begin
        r = $urandom_range(99);
        if (r < 40) begin
          fl = F_ACK;
          if ($urandom_range(99) < 6) fl |= F_FIN;
          if ($urandom_range(99) < 4) fl |= F_RST;
          if ($urandom_range(99) < 8) fl = F_FIN;
          send_item(CMD_SEG, fl, ($urandom_range(9) == 0) ? $urandom : sb.rcv_ack, pick_len());
        end else if (r < 55) begin
          send_item(CMD_WRITE, 0, 0, pick_len());
        end else if (r < 78) begin
          send_item(CMD_READ, 0, 0, pick_len());
        end else if (r < 84) begin
          send_item(CMD_CLOSE, 0, 0, 0);
        end else begin
          send_item(CMD_TICK, 0, 0, 0);
        end
      end
    endcase
  endtask

  initial begin
    logic [15:0] win_set[6]   = '{16'd65535, 16'd1, 16'd65535, 16'd100, 16'd37, 16'd2000};
    logic [15:0] twait_set[6] = '{16'd3, 16'd1, 16'd65535, 16'd3, 16'd2, 16'd5};
    int send_set[6] = '{0, 62, 0, 17, 62, 0};
    int recv_set[6] = '{0, 0, 62, 17, 62, 0};
    sb = new();
    rst_n = 1'b0;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    in_ch.valid = 1'b0;
    in_ch.cmd = '0;
    in_ch.seg_flags = '0;
    in_ch.seg_seq = '0;
    in_ch.length = '0;
    cfg_ch.valid = 1'b0;
    cfg_ch.index = '0;
    cfg_ch.data = '0;
    out_ch.ready = 1'b0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    write_cfg(REG_TWAIT, 16'd2);
    send_item(CMD_UNUSED, 8'hFF, 32'hFFFF_FFFF, 16'hFFFF);
    send_item(CMD_CLOSE, 0, 0, 0);
    send_item(CMD_TICK, 0, 0, 0);
    send_item(CMD_LISTEN, 0, 0, 0);
    send_item(CMD_LISTEN, 0, 0, 0);
    send_item(CMD_SEG, F_SYN, 32'hFFFF_FFFF, 0);
    send_item(CMD_CONNECT, 0, 0, 0);
    send_item(CMD_SEG, F_ACK, 0, 0);
    send_item(CMD_SEG, F_ACK, sb.rcv_ack, 0);
    send_item(CMD_SEG, F_ACK, sb.rcv_ack, 16'd10);
    send_item(CMD_SEG, F_ACK | F_RST, sb.rcv_ack, 16'd5);
    send_item(CMD_SEG, F_ACK, sb.rcv_ack + 1, 16'd5);
    send_item(CMD_SEG, F_ACK, sb.rcv_ack, 16'hFFFF);
    send_item(CMD_WRITE, 0, 0, 16'hFFFF);
    send_item(CMD_READ, 0, 0, 16'd3);
    send_item(CMD_READ, 0, 0, 16'hFFFF);
    send_item(CMD_READ, 0, 0, 16'd0);
    send_item(CMD_SEG, F_FIN | F_ACK, sb.rcv_ack, 16'd4);
    send_item(CMD_CLOSE, 0, 0, 0);
    send_item(CMD_SEG, F_ACK, 0, 0);
    send_item(CMD_TICK, 0, 0, 0);
    send_item(CMD_TICK, 0, 0, 0);
    send_item(CMD_CONNECT, 0, 0, 0);
    send_item(CMD_SEG, F_SYN | F_ACK, 32'h0, 0);
    send_item(CMD_CLOSE, 0, 0, 0);
    send_item(CMD_SEG, F_FIN, sb.rcv_ack, 0);
    send_item(CMD_SEG, F_ACK, 0, 0);
    send_item(CMD_SEG, F_FIN, 0, 0);
    drain();

    for (int ph = 0; ph < 6; ph++) begin
      write_cfg(REG_WINDOW, win_set[ph]);
      write_cfg(REG_TWAIT, twait_set[ph]);
      send_idle_pct = send_set[ph];
      recv_stall_pct = recv_set[ph];
      for (int n = 0; n < 305; n++) begin
        if (ph == 3 && n == 150) begin
          while (sb.expq.size() != 0) @(negedge clk);
        end
        random_item();
      end
      drain();
    end

    if (sb.errors == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
